/* rtl/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types, constants and helpers of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int NUM_FRAMES   = 4096;
    localparam int WORD_BITS    = 32;
    localparam int BITMAP_WORDS = NUM_FRAMES / WORD_BITS;
    localparam int WADDR_W      = $clog2(BITMAP_WORDS);
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int FRAME_W      = 12;
    localparam int WIU_W        = 8;
    localparam logic [WIU_W-1:0] WIU_RESET = WIU_W'(BITMAP_WORDS);

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [WADDR_W-1:0]   t_waddr;
    typedef logic [FRAME_W-1:0]   t_frame;
    typedef logic [WIU_W-1:0]     t_wiu;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STAT_DONE = 2'd0,
        STAT_NOP  = 2'd1,
        STAT_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_CHECK,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op    op;
        t_frame current_frame;
        logic   kernel_page;
        logic   writable_page;
    } t_req;

    typedef struct packed {
        t_status status;
        t_frame  new_frame;
        logic    present_bit;
        logic    writable_bit;
        logic    user_bit;
    } t_rsp;

    // bitmap access from the engine to the store
    typedef struct packed {
        logic   we;
        t_waddr waddr;
        t_word  wdata;
        t_waddr raddr;
    } t_mem_req;

    // position of the lowest clear bit, zero when none
    function automatic logic [BIT_W-1:0] first_zero(input t_word w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (!w[k]) begin
                pos = BIT_W'(k);
            end
        end
        return pos;
    endfunction

endpackage

/* rtl/bfa_if.sv */
// ----------------------------------------------------------------------------
// bfa_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface bfa_req_if import bfa_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/bfa_ram.sv */
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bfa_store.sv */
// ----------------------------------------------------------------------------
// bfa_store
// Bitmap storage: RAM plus per-word valid bits so reset frees every frame.
// ----------------------------------------------------------------------------
module bfa_store import bfa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_mem,
    output t_word    o_rdata
);

    logic [BITMAP_WORDS-1:0] r_valid;
    logic                    r_rd_valid;
    t_word                   ram_q;

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BITMAP_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_mem.we),
        .i_waddr (i_mem.waddr),
        .i_wdata (i_mem.wdata),
        .i_raddr (i_mem.raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_mem.we) begin
                r_valid[i_mem.waddr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_mem.raddr];
        end
    end

    // a word never written since reset reads as all free
    assign o_rdata = r_rd_valid ? ram_q : '0;

endmodule

/* rtl/bfa_engine.sv */
// ----------------------------------------------------------------------------
// bfa_engine
// Request sequencer: first-fit scan, read-modify-write, result register.
// ----------------------------------------------------------------------------
module bfa_engine import bfa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_wiu             i_words_in_use,
    bfa_req_if.sink          i_req,
    bfa_rsp_if.source        o_rsp,
    output t_mem_req         o_mem,
    input  t_word            i_rdata
);

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    t_frame           r_cur, n_cur;
    logic             r_kern, n_kern;
    logic             r_wr, n_wr;
    t_wiu             r_limit, n_limit;
    t_waddr           r_idx, n_idx;
    t_rsp             r_res, n_res;
    logic             r_ov, n_ov;
    t_rsp             r_out, n_out;

    logic             accept;
    logic             is_last;
    logic             word_full;
    logic [BIT_W-1:0] zero_pos;
    t_wiu             sat_limit;
    t_wiu             idx_next;

    assign accept    = i_req.valid && i_req.ready;
    assign word_full = (i_rdata == '1);
    assign zero_pos  = first_zero(i_rdata);
    assign idx_next  = WIU_W'(r_idx) + WIU_W'(1);
    assign is_last   = (idx_next >= r_limit);
    assign sat_limit = (i_words_in_use > WIU_RESET) ? WIU_RESET : i_words_in_use;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.payload.op == OP_ALLOC) begin
                        if (i_req.payload.current_frame != '0 || sat_limit == '0) begin
                            n_state = S_OUT;
                        end else begin
                            n_state = S_ISSUE;
                        end
                    end else begin
                        n_state = (i_req.payload.current_frame == '0) ? S_OUT : S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_op == OP_FREE || !word_full || is_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_op    = r_op;
        n_cur   = r_cur;
        n_kern  = r_kern;
        n_wr    = r_wr;
        n_limit = r_limit;
        n_idx   = r_idx;
        n_res   = r_res;
        n_ov    = r_ov;
        n_out   = r_out;

        i_req.ready = (r_state == S_IDLE);
        o_mem.we    = 1'b0;
        o_mem.waddr = r_idx;
        o_mem.wdata = i_rdata;
        o_mem.raddr = r_idx;

        if (o_rsp.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op    = i_req.payload.op;
                    n_cur   = i_req.payload.current_frame;
                    n_kern  = i_req.payload.kernel_page;
                    n_wr    = i_req.payload.writable_page;
                    n_limit = sat_limit;
                    n_res   = '{status: STAT_NOP, new_frame: '0, present_bit: 1'b0,
                                writable_bit: 1'b0, user_bit: 1'b0};
                    if (i_req.payload.op == OP_ALLOC) begin
                        n_idx = '0;
                        if (i_req.payload.current_frame != '0) begin
                            n_res.new_frame = i_req.payload.current_frame;
                        end else if (sat_limit == '0) begin
                            n_res.status = STAT_FULL;
                        end
                    end else begin
                        n_idx = i_req.payload.current_frame[FRAME_W-1:BIT_W];
                    end
                end
            end
            S_ISSUE: begin
                o_mem.raddr = r_idx;
            end
            S_CHECK: begin
                // prefetch the next word while this one is checked
                o_mem.raddr = idx_next[WADDR_W-1:0];
                if (r_op == OP_FREE) begin
                    o_mem.we    = 1'b1;
                    o_mem.wdata = i_rdata & ~(t_word'(1) << r_cur[BIT_W-1:0]);
                    n_res.status = STAT_DONE;
                end else if (!word_full) begin
                    o_mem.we           = 1'b1;
                    o_mem.wdata        = i_rdata | (t_word'(1) << zero_pos);
                    n_res.status       = STAT_DONE;
                    n_res.new_frame    = FRAME_W'({r_idx, zero_pos});
                    n_res.present_bit  = 1'b1;
                    n_res.writable_bit = r_wr;
                    n_res.user_bit     = !r_kern;
                end else if (is_last) begin
                    n_res.status = STAT_FULL;
                end else begin
                    n_idx = idx_next[WADDR_W-1:0];
                end
            end
            S_OUT: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov  = 1'b1;
                    n_out = r_res;
                end
            end
            default: begin
                n_ov = r_ov;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_op    <= n_op;
        r_cur   <= n_cur;
        r_kern  <= n_kern;
        r_wr    <= n_wr;
        r_limit <= n_limit;
        r_idx   <= n_idx;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_rsp.valid   = r_ov;
    assign o_rsp.payload = r_out;

`ifndef SYNTHESIS
    a_write_in_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.we |-> r_state == S_CHECK)
        else $error("bitmap write outside check state");

    a_alloc_sets_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem.we && r_op == OP_ALLOC) |->
            $countones(o_mem.wdata) == $countones(i_rdata) + 1)
        else $error("allocate did not mark exactly one frame");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && r_op == OP_ALLOC) |-> WIU_W'(r_idx) < r_limit)
        else $error("scan beyond words in use");

    a_present_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.present_bit) |-> r_out.status == STAT_DONE)
        else $error("present bit on a result that is not done");
`endif

endmodule

/* rtl/bitmap_frame_allocator_top.sv */
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// First-fit page-frame allocator over a one-bit-per-frame bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   i_req  carries one request (op, current_frame, kernel_page, writable_page);
//          it is taken when valid and ready are both high.
//   o_rsp  returns exactly one result per request, in order, held in an
//          output register until the receiver takes it.
//   i_cfg_we / i_cfg_wdata write words_in_use (reset 128, saturates at 128);
//          write it only while no request is in flight.
// Sequence:
//   a request that needs no bitmap access (frame already set, nothing to
//   free) passes S_OUT; a free passes S_ISSUE, S_CHECK and S_OUT. An
//   allocate reads one bitmap word per cycle from a single RAM read port:
//   S_ISSUE, then S_CHECK per word scanned (1 to words_in_use, at most
//   128), then S_OUT. One request at a time is worked on; the next is
//   taken in the cycle after the prior result loads, which may still wait.
// Reset: the bitmap reads as all free (per-word valid bits), the result
//   register empties and no clearing sweep is needed.
// Stall: while the previous result is not taken, a finished request waits
//   in S_OUT and no further request is accepted.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top import bfa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  t_wiu       i_cfg_wdata,
    bfa_req_if.sink    i_req,
    bfa_rsp_if.source  o_rsp
);

    t_wiu     r_words_in_use;
    t_mem_req mem;
    t_word    rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_in_use <= WIU_RESET;
        end else if (i_cfg_we) begin
            r_words_in_use <= i_cfg_wdata;
        end
    end

    bfa_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_words_in_use (r_words_in_use),
        .i_req          (i_req),
        .o_rsp          (o_rsp),
        .o_mem          (mem),
        .i_rdata        (rdata)
    );

    bfa_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mem   (mem),
        .o_rdata (rdata)
    );

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitmap frame allocator. A short directed list
// and several random phases with different search lengths run through the
// allocator. A running copy of the frame bitmap predicts every result, and
// results are checked in order against it.
// ----------------------------------------------------------------------------
module tb;
    import bfa_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 140;
    localparam int PHASES       = 10;
    localparam int PHASE_REQS   = 55;
    localparam int CALM_REQS    = 40;

    typedef enum logic [1:0] {
        PLAN_REQ,
        PLAN_CFG,
        PLAN_SETTLE
    } t_plan_kind;

    typedef struct {
        t_plan_kind kind;
        t_req       req;
        t_wiu       wiu;
        logic       may_idle;
        logic       tail;
    } t_plan;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cfg_we    = 1'b0;
    t_wiu cfg_wdata = '0;
    logic req_valid = 1'b0;
    t_req req_data  = '0;
    logic rsp_ready = 1'b0;
    logic calm_tail = 1'b0;

    // predicted allocator state
    t_word frame_map [BITMAP_WORDS];
    t_wiu  search_words = WIU_RESET;

    t_plan req_plan [$];
    t_rsp  owed_rsp [$];
    int    fault_count = 0;
    int    cycle_count = 0;
    int    gap_left    = 0;
    int    stall_left  = 0;
    int    run_left    = 0;
    logic  gen_idle    = 1'b1;
    logic  gen_tail    = 1'b0;

    bfa_req_if req_if ();
    bfa_rsp_if rsp_if ();

    assign req_if.valid   = req_valid;
    assign req_if.payload = req_data;
    assign rsp_if.ready   = rsp_ready;

    bitmap_frame_allocator_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // first fit over the searched words, or release of the named frame
    function automatic t_rsp serve_entry(input t_req r);
        t_rsp rsp;
        int   span;
        int   hit;
        int   w;
        int   b;
        rsp = '0;
        rsp.status = STAT_NOP;
        if (r.op == OP_ALLOC) begin
            if (r.current_frame != '0) begin
                rsp.new_frame = r.current_frame;
            end else begin
                span = (int'(search_words) > BITMAP_WORDS) ? BITMAP_WORDS
                                                            : int'(search_words);
                hit = -1;
                for (w = 0; w < span && hit < 0; w++) begin
                    for (b = 0; b < WORD_BITS && hit < 0; b++) begin
                        if (!frame_map[w][b]) begin
                            hit = w * WORD_BITS + b;
                        end
                    end
                end
                if (hit < 0) begin
                    rsp.status = STAT_FULL;
                end else begin
                    frame_map[hit / WORD_BITS][hit % WORD_BITS] = 1'b1;
                    rsp.status       = STAT_DONE;
                    rsp.new_frame    = t_frame'(hit);
                    rsp.present_bit  = 1'b1;
                    rsp.writable_bit = r.writable_page;
                    rsp.user_bit     = !r.kernel_page;
                end
            end
        end else if (r.current_frame != '0) begin
            if (int'(r.current_frame) < NUM_FRAMES) begin
                frame_map[r.current_frame / WORD_BITS][r.current_frame % WORD_BITS] = 1'b0;
            end
            rsp.status = STAT_DONE;
        end
        return rsp;
    endfunction

    task automatic plan_req(input t_op op, input int cur, input logic kern, input logic wr);
        t_plan p;
        p.kind                 = PLAN_REQ;
        p.req.op               = op;
        p.req.current_frame    = t_frame'(cur);
        p.req.kernel_page      = kern;
        p.req.writable_page    = wr;
        p.wiu                  = '0;
        p.may_idle             = gen_idle;
        p.tail                 = gen_tail;
        req_plan.push_back(p);
    endtask

    task automatic plan_ctrl(input t_plan_kind kind, input int words);
        t_plan p;
        p.kind     = kind;
        p.req      = '0;
        p.wiu      = t_wiu'(words);
        p.may_idle = 1'b0;
        p.tail     = 1'b0;
        req_plan.push_back(p);
    endtask

    task automatic flag_mismatch(input string fld, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
        fault_count++;
    endtask

    // request driver: waits for idle before register writes and settle points
    always @(posedge clk) begin : driver
        logic  nxt_valid;
        t_req  nxt_data;
        logic  nxt_we;
        t_plan head;
        nxt_valid = req_valid;
        nxt_data  = req_data;
        nxt_we    = 1'b0;
        if (rst_n) begin
            if (req_valid && req_if.ready) begin
                owed_rsp.push_back(serve_entry(req_data));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && req_plan.size() > 0) begin
                head = req_plan[0];
                case (head.kind)
                    PLAN_REQ: begin
                        if (gap_left > 0) begin
                            gap_left--;
                        end else if (head.may_idle && $urandom_range(0, 4) == 0) begin
                            gap_left = $urandom_range(0, 16);
                        end else begin
                            nxt_valid = 1'b1;
                            nxt_data  = head.req;
                            void'(req_plan.pop_front());
                            if (head.tail) begin
                                calm_tail <= 1'b1;
                            end
                        end
                    end
                    PLAN_CFG: begin
                        if (owed_rsp.size() == 0) begin
                            nxt_we       = 1'b1;
                            cfg_wdata    <= head.wiu;
                            search_words = head.wiu;
                            void'(req_plan.pop_front());
                        end
                    end
                    default: begin
                        if (owed_rsp.size() == 0) begin
                            void'(req_plan.pop_front());
                        end
                    end
                endcase
            end
        end
        req_valid <= nxt_valid;
        req_data  <= nxt_data;
        cfg_we    <= nxt_we;
    end

    // result monitor with random back-pressure
    always @(posedge clk) begin : monitor
        t_rsp want;
        t_rsp got;
        logic nxt_ready;
        if (rst_n) begin
            if (rsp_if.valid && rsp_ready) begin
                got = rsp_if.payload;
                if (owed_rsp.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, got);
                    fault_count++;
                end else begin
                    want = owed_rsp.pop_front();
                    if (got.status !== want.status)
                        flag_mismatch("status", 32'(want.status), 32'(got.status));
                    if (got.new_frame !== want.new_frame)
                        flag_mismatch("new_frame", 32'(want.new_frame),
                                      32'(got.new_frame));
                    if (got.present_bit !== want.present_bit)
                        flag_mismatch("present_bit", 32'(want.present_bit),
                                      32'(got.present_bit));
                    if (got.writable_bit !== want.writable_bit)
                        flag_mismatch("writable_bit", 32'(want.writable_bit),
                                      32'(got.writable_bit));
                    if (got.user_bit !== want.user_bit)
                        flag_mismatch("user_bit", 32'(want.user_bit), 32'(got.user_bit));
                end
            end
            nxt_ready = 1'b1;
            if (calm_tail) begin
                stall_left = 0;
            end else if (run_left > 0) begin
                run_left--;
            end else if (stall_left > 0) begin
                stall_left--;
                nxt_ready = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 16);
                nxt_ready  = 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                run_left = $urandom_range(20, 80);
            end
            rsp_ready <= nxt_ready;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int phase_words [PHASES];
        int eff;
        int span;
        int pick;
        foreach (frame_map[w]) begin
            frame_map[w] = '0;
        end

        // directed: frame zero handed out, already set, nothing to free, reuse
        plan_req(OP_ALLOC, 0, 1'b0, 1'b1);
        plan_req(OP_ALLOC, 0, 1'b1, 1'b0);
        plan_req(OP_ALLOC, 0, 1'b1, 1'b1);
        plan_req(OP_ALLOC, 0, 1'b0, 1'b0);
        plan_req(OP_ALLOC, 12'hFFF, 1'b1, 1'b1);
        plan_req(OP_ALLOC, 1, 1'b0, 1'b0);
        plan_req(OP_FREE, 0, 1'b1, 1'b1);
        plan_req(OP_FREE, 2, 1'b0, 1'b0);
        plan_req(OP_ALLOC, 0, 1'b1, 1'b1);
        plan_req(OP_FREE, 12'hFFF, 1'b1, 1'b1);
        plan_ctrl(PLAN_SETTLE, 0);
        // empty search, then saturated search length
        plan_ctrl(PLAN_CFG, 0);
        plan_req(OP_ALLOC, 0, 1'b0, 1'b1);
        plan_req(OP_FREE, 1, 1'b0, 1'b0);
        plan_req(OP_ALLOC, 0, 1'b1, 1'b0);
        plan_ctrl(PLAN_CFG, 255);
        plan_req(OP_ALLOC, 0, 1'b0, 1'b1);
        plan_req(OP_ALLOC, 0, 1'b1, 1'b1);
        // single word search, free beyond the searched words
        plan_ctrl(PLAN_CFG, 1);
        plan_req(OP_FREE, 12'h800, 1'b0, 1'b1);
        plan_req(OP_FREE, 3, 1'b1, 1'b0);
        plan_req(OP_ALLOC, 0, 1'b0, 1'b0);

        phase_words = '{1, 2, 128, 0, 255, 3, 1, 1, 4, 128};
        phase_words[6] = $urandom_range(1, 128);
        for (int ph = 0; ph < PHASES; ph++) begin
            plan_ctrl(PLAN_CFG, phase_words[ph]);
            eff  = (phase_words[ph] > BITMAP_WORDS) ? BITMAP_WORDS : phase_words[ph];
            span = (eff == 0) ? 63 : eff * WORD_BITS + WORD_BITS - 1;
            if (span > 255) begin
                span = 255;
            end
            for (int k = 0; k < PHASE_REQS; k++) begin
                if (k % 20 == 0) begin
                    gen_idle = ($urandom_range(0, 3) != 0);
                end
                if (ph == PHASES - 1 && k >= PHASE_REQS - CALM_REQS) begin
                    gen_idle = 1'b0;
                    gen_tail = 1'b1;
                end else if ($urandom_range(0, 39) == 0) begin
                    plan_ctrl(PLAN_SETTLE, 0);
                end
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    plan_req(OP_ALLOC, 0, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
                end else if (pick < 9) begin
                    plan_req(OP_FREE, $urandom_range(1, span), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
                end else begin
                    plan_req(t_op'($urandom_range(0, 1)), $urandom_range(0, 4095),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        do begin
            @(negedge clk);
        end while (req_plan.size() != 0 || req_valid || owed_rsp.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fault_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
